/* rtl/core/sclp_pkg.sv */
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared sizes, opcodes, sequencer states and control structs for the
// strongly connected component / longest condensed path block.
// ----------------------------------------------------------------------------
package sclp_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int FIELD_W = 11;                        // port field width
    localparam int VX_W    = $clog2(MAX_NODES);         // vertex index
    localparam int NC_W    = $clog2(MAX_NODES + 1);     // vertex count / id
    localparam int EA_W    = $clog2(MAX_EDGES);         // edge address
    localparam int EC_W    = $clog2(MAX_EDGES + 1);     // edge count / offset
    localparam int STK_W   = VX_W + 2 * EC_W;           // {node, pos, end}

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_EDGE,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_FIL_RD,
        S_FIL_EDGE,
        S_FIL_WR,
        S_F_OUTER,
        S_F_CHK,
        S_F_OPEN1,
        S_F_OPEN2,
        S_F_STEP,
        S_F_ADJ,
        S_F_VIS,
        S_F_POP,
        S_R_OUTER,
        S_R_SEED,
        S_R_SCHK,
        S_R_OPEN1,
        S_R_OPEN2,
        S_R_STEP,
        S_R_ADJ,
        S_R_CMP,
        S_R_BEST,
        S_R_POP,
        S_R_DONE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic               load;
        logic               run;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] node_count;
    } t_core_cmd;

    typedef struct packed {
        logic            idle;
        logic            done;
        logic [NC_W-1:0] best;
        logic            ovf;
    } t_core_sts;

endpackage

/* rtl/core/sclp_req_if.sv */
// ----------------------------------------------------------------------------
// sclp_req_if
// Input item channel: opcode and edge endpoints, valid/ready.
// ----------------------------------------------------------------------------
interface sclp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [sclp_pkg::FIELD_W-1:0] source_node;
    logic [sclp_pkg::FIELD_W-1:0] target_node;

    modport source (output valid, opcode, source_node, target_node, input ready);
    modport sink   (input valid, opcode, source_node, target_node, output ready);
endinterface

/* rtl/core/sclp_rsp_if.sv */
// ----------------------------------------------------------------------------
// sclp_rsp_if
// Result channel: longest condensed path total and overflow flag.
// ----------------------------------------------------------------------------
interface sclp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sclp_pkg::FIELD_W-1:0] best_path_nodes;
    logic                        edge_overflow;

    modport source (output valid, best_path_nodes, edge_overflow, input ready);
    modport sink   (input valid, best_path_nodes, edge_overflow, output ready);
endinterface

/* rtl/core/sclp_core.sv */
// ----------------------------------------------------------------------------
// sclp_core
// Edge store plus memory-based sequencer: CSR build, forward walk, reverse
// walk with per-component longest path accumulation.
// ----------------------------------------------------------------------------
module sclp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sclp_pkg::t_core_cmd i_cmd,
    input  logic                i_out_free,
    output sclp_pkg::t_core_sts o_sts
);

    sclp_pkg::t_state r_state, n_state;

    logic [sclp_pkg::EC_W-1:0] r_tot;
    logic                      r_ovf;
    logic [sclp_pkg::NC_W-1:0] r_n;
    logic [sclp_pkg::EC_W-1:0] r_i;
    logic [sclp_pkg::EC_W-1:0] r_oacc, r_iacc;
    logic [sclp_pkg::VX_W-1:0] r_node;
    logic [sclp_pkg::EC_W-1:0] r_pos, r_end;
    logic [sclp_pkg::VX_W-1:0] r_sp;
    logic [sclp_pkg::NC_W-1:0] r_done;
    logic [sclp_pkg::NC_W-1:0] r_cid, r_size, r_amax, r_best;

    // memories
    logic [2*sclp_pkg::VX_W-1:0] m_edge [sclp_pkg::MAX_EDGES];
    logic [sclp_pkg::EC_W-1:0]   m_ofs  [sclp_pkg::MAX_NODES+1];
    logic [sclp_pkg::EC_W-1:0]   m_ifs  [sclp_pkg::MAX_NODES+1];
    logic [sclp_pkg::VX_W-1:0]   m_oadj [sclp_pkg::MAX_EDGES];
    logic [sclp_pkg::VX_W-1:0]   m_iadj [sclp_pkg::MAX_EDGES];
    logic                        m_vis  [sclp_pkg::MAX_NODES];
    logic [sclp_pkg::NC_W-1:0]   m_comp [sclp_pkg::MAX_NODES];
    logic [sclp_pkg::VX_W-1:0]   m_fin  [sclp_pkg::MAX_NODES];
    logic [sclp_pkg::STK_W-1:0]  m_stk  [sclp_pkg::MAX_NODES];
    logic [sclp_pkg::NC_W-1:0]   m_best [sclp_pkg::MAX_NODES];

    logic [2*sclp_pkg::VX_W-1:0] r_eg_q;
    logic [sclp_pkg::EC_W-1:0]   r_of_q, r_if_q;
    logic [sclp_pkg::VX_W-1:0]   r_oa_q, r_ia_q;
    logic                        r_vi_q;
    logic [sclp_pkg::NC_W-1:0]   r_cp_q;
    logic [sclp_pkg::VX_W-1:0]   r_fo_q;
    logic [sclp_pkg::STK_W-1:0]  r_st_q;
    logic [sclp_pkg::NC_W-1:0]   r_bs_q;

    logic eg_re, eg_we, of_re, of_we, if_re, if_we, oa_re, oa_we, ia_re, ia_we;
    logic vi_re, vi_we, cp_re, cp_we, fo_re, fo_we, st_re, st_we, bs_re, bs_we;
    logic [sclp_pkg::EA_W-1:0]   eg_ra, eg_wa, oa_ra, oa_wa, ia_ra, ia_wa;
    logic [sclp_pkg::NC_W-1:0]   of_ra, of_wa, if_ra, if_wa;
    logic [sclp_pkg::VX_W-1:0]   vi_ra, vi_wa, cp_ra, cp_wa, fo_ra, fo_wa;
    logic [sclp_pkg::VX_W-1:0]   st_ra, st_wa, bs_ra, bs_wa;
    logic [2*sclp_pkg::VX_W-1:0] eg_wd;
    logic [sclp_pkg::EC_W-1:0]   of_wd, if_wd;
    logic [sclp_pkg::VX_W-1:0]   oa_wd, ia_wd, fo_wd;
    logic                        vi_wd;
    logic [sclp_pkg::NC_W-1:0]   cp_wd, bs_wd;
    logic [sclp_pkg::STK_W-1:0]  st_wd;

    logic [sclp_pkg::VX_W-1:0] w_efrom, w_eto;
    logic                      w_evalid;
    logic                      w_src_ok, w_dst_ok, w_full, w_ld_ok;
    logic                      w_i_tot, w_i_n, w_more;
    logic [sclp_pkg::NC_W-1:0] w_nclamp, w_cand;

    assign w_efrom  = r_eg_q[2*sclp_pkg::VX_W-1:sclp_pkg::VX_W];
    assign w_eto    = r_eg_q[sclp_pkg::VX_W-1:0];
    assign w_evalid = (sclp_pkg::NC_W'(w_efrom) < r_n) && (sclp_pkg::NC_W'(w_eto) < r_n);
    assign w_src_ok = (i_cmd.src != '0)
                   && (i_cmd.src <= sclp_pkg::FIELD_W'(sclp_pkg::MAX_NODES));
    assign w_dst_ok = (i_cmd.dst != '0)
                   && (i_cmd.dst <= sclp_pkg::FIELD_W'(sclp_pkg::MAX_NODES));
    assign w_full   = (r_tot == sclp_pkg::EC_W'(sclp_pkg::MAX_EDGES));
    assign w_ld_ok  = i_cmd.load && w_src_ok && w_dst_ok;
    assign w_i_tot  = (r_i == r_tot);
    assign w_i_n    = (r_i == sclp_pkg::EC_W'(r_n));
    assign w_more   = (r_pos < r_end);
    assign w_nclamp = (i_cmd.node_count > sclp_pkg::FIELD_W'(sclp_pkg::MAX_NODES))
                    ? sclp_pkg::NC_W'(sclp_pkg::MAX_NODES)
                    : sclp_pkg::NC_W'(i_cmd.node_count);
    assign w_cand   = r_amax + r_size;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sclp_pkg::S_IDLE:     if (i_cmd.run) n_state = sclp_pkg::S_CLR;
            sclp_pkg::S_CLR:
                if (r_i == sclp_pkg::EC_W'(sclp_pkg::MAX_NODES)) n_state = sclp_pkg::S_CNT_RD;
            sclp_pkg::S_CNT_RD:
                n_state = w_i_tot ? sclp_pkg::S_PFX_RD : sclp_pkg::S_CNT_EDGE;
            sclp_pkg::S_CNT_EDGE:
                n_state = w_evalid ? sclp_pkg::S_CNT_WR : sclp_pkg::S_CNT_RD;
            sclp_pkg::S_CNT_WR:   n_state = sclp_pkg::S_CNT_RD;
            sclp_pkg::S_PFX_RD:   n_state = sclp_pkg::S_PFX_WR;
            sclp_pkg::S_PFX_WR:
                n_state = w_i_n ? sclp_pkg::S_FIL_RD : sclp_pkg::S_PFX_RD;
            sclp_pkg::S_FIL_RD:
                n_state = w_i_tot ? sclp_pkg::S_F_OUTER : sclp_pkg::S_FIL_EDGE;
            sclp_pkg::S_FIL_EDGE:
                n_state = w_evalid ? sclp_pkg::S_FIL_WR : sclp_pkg::S_FIL_RD;
            sclp_pkg::S_FIL_WR:   n_state = sclp_pkg::S_FIL_RD;
            sclp_pkg::S_F_OUTER:
                n_state = w_i_n ? sclp_pkg::S_R_OUTER : sclp_pkg::S_F_CHK;
            sclp_pkg::S_F_CHK:
                n_state = r_vi_q ? sclp_pkg::S_F_OUTER : sclp_pkg::S_F_OPEN1;
            sclp_pkg::S_F_OPEN1:  n_state = sclp_pkg::S_F_OPEN2;
            sclp_pkg::S_F_OPEN2:  n_state = sclp_pkg::S_F_STEP;
            sclp_pkg::S_F_STEP:
                if (w_more)           n_state = sclp_pkg::S_F_ADJ;
                else if (r_sp == '0)  n_state = sclp_pkg::S_F_OUTER;
                else                  n_state = sclp_pkg::S_F_POP;
            sclp_pkg::S_F_ADJ:    n_state = sclp_pkg::S_F_VIS;
            sclp_pkg::S_F_VIS:
                n_state = r_vi_q ? sclp_pkg::S_F_STEP : sclp_pkg::S_F_OPEN1;
            sclp_pkg::S_F_POP:    n_state = sclp_pkg::S_F_STEP;
            sclp_pkg::S_R_OUTER:
                n_state = (r_i == '0) ? sclp_pkg::S_FIN : sclp_pkg::S_R_SEED;
            sclp_pkg::S_R_SEED:   n_state = sclp_pkg::S_R_SCHK;
            sclp_pkg::S_R_SCHK:
                n_state = (r_cp_q != '0) ? sclp_pkg::S_R_OUTER : sclp_pkg::S_R_OPEN1;
            sclp_pkg::S_R_OPEN1:  n_state = sclp_pkg::S_R_OPEN2;
            sclp_pkg::S_R_OPEN2:  n_state = sclp_pkg::S_R_STEP;
            sclp_pkg::S_R_STEP:
                if (w_more)           n_state = sclp_pkg::S_R_ADJ;
                else if (r_sp == '0)  n_state = sclp_pkg::S_R_DONE;
                else                  n_state = sclp_pkg::S_R_POP;
            sclp_pkg::S_R_ADJ:    n_state = sclp_pkg::S_R_CMP;
            sclp_pkg::S_R_CMP:
                if (r_cp_q == '0)        n_state = sclp_pkg::S_R_OPEN1;
                else if (r_cp_q != r_cid) n_state = sclp_pkg::S_R_BEST;
                else                     n_state = sclp_pkg::S_R_STEP;
            sclp_pkg::S_R_BEST:   n_state = sclp_pkg::S_R_STEP;
            sclp_pkg::S_R_POP:    n_state = sclp_pkg::S_R_STEP;
            sclp_pkg::S_R_DONE:   n_state = sclp_pkg::S_R_OUTER;
            sclp_pkg::S_FIN:      if (i_out_free) n_state = sclp_pkg::S_IDLE;
            default:              n_state = sclp_pkg::S_IDLE;
        endcase
    end

    // memory port controls and status
    always_comb begin
        eg_re = 1'b0; eg_we = 1'b0; eg_ra = '0; eg_wa = '0; eg_wd = '0;
        of_re = 1'b0; of_we = 1'b0; of_ra = '0; of_wa = '0; of_wd = '0;
        if_re = 1'b0; if_we = 1'b0; if_ra = '0; if_wa = '0; if_wd = '0;
        oa_re = 1'b0; oa_we = 1'b0; oa_ra = '0; oa_wa = '0; oa_wd = '0;
        ia_re = 1'b0; ia_we = 1'b0; ia_ra = '0; ia_wa = '0; ia_wd = '0;
        vi_re = 1'b0; vi_we = 1'b0; vi_ra = '0; vi_wa = '0; vi_wd = 1'b0;
        cp_re = 1'b0; cp_we = 1'b0; cp_ra = '0; cp_wa = '0; cp_wd = '0;
        fo_re = 1'b0; fo_we = 1'b0; fo_ra = '0; fo_wa = '0; fo_wd = '0;
        st_re = 1'b0; st_we = 1'b0; st_ra = '0; st_wa = '0; st_wd = '0;
        bs_re = 1'b0; bs_we = 1'b0; bs_ra = '0; bs_wa = '0; bs_wd = '0;
        o_sts.idle = (r_state == sclp_pkg::S_IDLE);
        o_sts.done = (r_state == sclp_pkg::S_FIN) && i_out_free;
        o_sts.best = r_best;
        o_sts.ovf  = r_ovf;
        unique case (r_state)
            sclp_pkg::S_IDLE: begin
                eg_we = w_ld_ok && !w_full;
                eg_wa = r_tot[sclp_pkg::EA_W-1:0];
                eg_wd = {sclp_pkg::VX_W'(i_cmd.src - 1'b1), sclp_pkg::VX_W'(i_cmd.dst - 1'b1)};
            end
            sclp_pkg::S_CLR: begin
                of_we = 1'b1; of_wa = r_i[sclp_pkg::NC_W-1:0];
                if_we = 1'b1; if_wa = r_i[sclp_pkg::NC_W-1:0];
                vi_we = (r_i < sclp_pkg::EC_W'(sclp_pkg::MAX_NODES));
                vi_wa = r_i[sclp_pkg::VX_W-1:0];
                cp_we = vi_we; cp_wa = r_i[sclp_pkg::VX_W-1:0];
            end
            sclp_pkg::S_CNT_RD, sclp_pkg::S_FIL_RD: begin
                eg_re = !w_i_tot; eg_ra = r_i[sclp_pkg::EA_W-1:0];
            end
            sclp_pkg::S_CNT_EDGE, sclp_pkg::S_FIL_EDGE: begin
                of_re = w_evalid; of_ra = sclp_pkg::NC_W'(w_efrom);
                if_re = w_evalid; if_ra = sclp_pkg::NC_W'(w_eto);
            end
            sclp_pkg::S_CNT_WR: begin
                of_we = 1'b1; of_wa = sclp_pkg::NC_W'(w_efrom); of_wd = r_of_q + 1'b1;
                if_we = 1'b1; if_wa = sclp_pkg::NC_W'(w_eto);   if_wd = r_if_q + 1'b1;
            end
            sclp_pkg::S_PFX_RD: begin
                of_re = 1'b1; of_ra = r_i[sclp_pkg::NC_W-1:0];
                if_re = 1'b1; if_ra = r_i[sclp_pkg::NC_W-1:0];
            end
            sclp_pkg::S_PFX_WR: begin
                of_we = 1'b1; of_wa = r_i[sclp_pkg::NC_W-1:0]; of_wd = r_oacc + r_of_q;
                if_we = 1'b1; if_wa = r_i[sclp_pkg::NC_W-1:0]; if_wd = r_iacc + r_if_q;
            end
            sclp_pkg::S_FIL_WR: begin
                // fill downward from the end offsets; entries end up as start offsets
                of_we = 1'b1; of_wa = sclp_pkg::NC_W'(w_efrom); of_wd = r_of_q - 1'b1;
                if_we = 1'b1; if_wa = sclp_pkg::NC_W'(w_eto);   if_wd = r_if_q - 1'b1;
                oa_we = 1'b1; oa_wa = of_wd[sclp_pkg::EA_W-1:0]; oa_wd = w_eto;
                ia_we = 1'b1; ia_wa = if_wd[sclp_pkg::EA_W-1:0]; ia_wd = w_efrom;
            end
            sclp_pkg::S_F_OUTER: begin
                vi_re = !w_i_n; vi_ra = r_i[sclp_pkg::VX_W-1:0];
            end
            sclp_pkg::S_F_CHK: begin
                vi_we = !r_vi_q; vi_wa = r_i[sclp_pkg::VX_W-1:0]; vi_wd = 1'b1;
                of_re = !r_vi_q; of_ra = sclp_pkg::NC_W'(r_i[sclp_pkg::VX_W-1:0]);
            end
            sclp_pkg::S_F_OPEN1: begin
                of_re = 1'b1; of_ra = sclp_pkg::NC_W'(r_node) + 1'b1;
            end
            sclp_pkg::S_F_STEP: begin
                oa_re = w_more; oa_ra = r_pos[sclp_pkg::EA_W-1:0];
                fo_we = !w_more; fo_wa = r_done[sclp_pkg::VX_W-1:0]; fo_wd = r_node;
                st_re = !w_more && (r_sp != '0); st_ra = r_sp - 1'b1;
            end
            sclp_pkg::S_F_ADJ: begin
                vi_re = 1'b1; vi_ra = r_oa_q;
            end
            sclp_pkg::S_F_VIS: begin
                vi_we = !r_vi_q; vi_wa = r_oa_q; vi_wd = 1'b1;
                st_we = !r_vi_q; st_wa = r_sp; st_wd = {r_node, r_pos, r_end};
                of_re = !r_vi_q; of_ra = sclp_pkg::NC_W'(r_oa_q);
            end
            sclp_pkg::S_R_OUTER: begin
                fo_re = (r_i != '0); fo_ra = sclp_pkg::VX_W'(r_i - 1'b1);
            end
            sclp_pkg::S_R_SEED: begin
                cp_re = 1'b1; cp_ra = r_fo_q;
            end
            sclp_pkg::S_R_SCHK: begin
                cp_we = (r_cp_q == '0); cp_wa = r_fo_q; cp_wd = r_cid + 1'b1;
                if_re = (r_cp_q == '0); if_ra = sclp_pkg::NC_W'(r_fo_q);
            end
            sclp_pkg::S_R_OPEN1: begin
                if_re = 1'b1; if_ra = sclp_pkg::NC_W'(r_node) + 1'b1;
            end
            sclp_pkg::S_R_STEP: begin
                ia_re = w_more; ia_ra = r_pos[sclp_pkg::EA_W-1:0];
                st_re = !w_more && (r_sp != '0); st_ra = r_sp - 1'b1;
            end
            sclp_pkg::S_R_ADJ: begin
                cp_re = 1'b1; cp_ra = r_ia_q;
            end
            sclp_pkg::S_R_CMP: begin
                cp_we = (r_cp_q == '0); cp_wa = r_ia_q; cp_wd = r_cid;
                st_we = (r_cp_q == '0); st_wa = r_sp; st_wd = {r_node, r_pos, r_end};
                if_re = (r_cp_q == '0); if_ra = sclp_pkg::NC_W'(r_ia_q);
                bs_re = (r_cp_q != '0) && (r_cp_q != r_cid);
                bs_ra = sclp_pkg::VX_W'(r_cp_q - 1'b1);
            end
            sclp_pkg::S_R_DONE: begin
                bs_we = 1'b1; bs_wa = sclp_pkg::VX_W'(r_cid - 1'b1); bs_wd = w_cand;
            end
            default: ;
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (eg_we) m_edge[eg_wa] <= eg_wd;
        if (eg_re) r_eg_q <= m_edge[eg_ra];
        if (of_we) m_ofs[of_wa] <= of_wd;
        if (of_re) r_of_q <= m_ofs[of_ra];
        if (if_we) m_ifs[if_wa] <= if_wd;
        if (if_re) r_if_q <= m_ifs[if_ra];
        if (oa_we) m_oadj[oa_wa] <= oa_wd;
        if (oa_re) r_oa_q <= m_oadj[oa_ra];
        if (ia_we) m_iadj[ia_wa] <= ia_wd;
        if (ia_re) r_ia_q <= m_iadj[ia_ra];
        if (vi_we) m_vis[vi_wa] <= vi_wd;
        if (vi_re) r_vi_q <= m_vis[vi_ra];
        if (cp_we) m_comp[cp_wa] <= cp_wd;
        if (cp_re) r_cp_q <= m_comp[cp_ra];
        if (fo_we) m_fin[fo_wa] <= fo_wd;
        if (fo_re) r_fo_q <= m_fin[fo_ra];
        if (st_we) m_stk[st_wa] <= st_wd;
        if (st_re) r_st_q <= m_stk[st_ra];
        if (bs_we) m_best[bs_wa] <= bs_wd;
        if (bs_re) r_bs_q <= m_best[bs_ra];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sclp_pkg::S_IDLE;
            r_tot   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                sclp_pkg::S_IDLE: begin
                    if (w_ld_ok) begin
                        if (w_full) r_ovf <= 1'b1;
                        else        r_tot <= r_tot + 1'b1;
                    end
                    if (i_cmd.run) begin
                        r_n <= w_nclamp;
                        r_i <= '0;
                    end
                end
                sclp_pkg::S_CLR:
                    r_i <= (r_i == sclp_pkg::EC_W'(sclp_pkg::MAX_NODES)) ? '0 : r_i + 1'b1;
                sclp_pkg::S_CNT_RD: begin
                    if (w_i_tot) begin
                        r_i    <= '0;
                        r_oacc <= '0;
                        r_iacc <= '0;
                    end
                end
                sclp_pkg::S_CNT_EDGE, sclp_pkg::S_FIL_EDGE:
                    if (!w_evalid) r_i <= r_i + 1'b1;
                sclp_pkg::S_CNT_WR, sclp_pkg::S_FIL_WR: r_i <= r_i + 1'b1;
                sclp_pkg::S_PFX_WR: begin
                    r_oacc <= r_oacc + r_of_q;
                    r_iacc <= r_iacc + r_if_q;
                    r_i    <= w_i_n ? '0 : r_i + 1'b1;
                end
                sclp_pkg::S_FIL_RD: begin
                    if (w_i_tot) begin
                        r_i    <= '0;
                        r_done <= '0;
                    end
                end
                sclp_pkg::S_F_OUTER: begin
                    if (w_i_n) begin
                        r_i    <= sclp_pkg::EC_W'(r_done);
                        r_cid  <= '0;
                        r_best <= '0;
                    end
                end
                sclp_pkg::S_F_CHK: begin
                    if (r_vi_q) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_node <= r_i[sclp_pkg::VX_W-1:0];
                        r_sp   <= '0;
                    end
                end
                sclp_pkg::S_F_OPEN1, sclp_pkg::S_R_OPEN1:
                    r_pos <= (r_state == sclp_pkg::S_F_OPEN1) ? r_of_q : r_if_q;
                sclp_pkg::S_F_OPEN2, sclp_pkg::S_R_OPEN2:
                    r_end <= (r_state == sclp_pkg::S_F_OPEN2) ? r_of_q : r_if_q;
                sclp_pkg::S_F_STEP: begin
                    if (w_more) begin
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_done <= r_done + 1'b1;
                        if (r_sp == '0) r_i  <= r_i + 1'b1;
                        else            r_sp <= r_sp - 1'b1;
                    end
                end
                sclp_pkg::S_F_ADJ: ;
                sclp_pkg::S_F_VIS: begin
                    if (!r_vi_q) begin
                        r_sp   <= r_sp + 1'b1;
                        r_node <= r_oa_q;
                    end
                end
                sclp_pkg::S_F_POP, sclp_pkg::S_R_POP:
                    {r_node, r_pos, r_end} <= r_st_q;
                sclp_pkg::S_R_OUTER: ;
                sclp_pkg::S_R_SEED: r_i <= r_i - 1'b1;
                sclp_pkg::S_R_SCHK: begin
                    if (r_cp_q == '0) begin
                        r_cid  <= r_cid + 1'b1;
                        r_node <= r_fo_q;
                        r_sp   <= '0;
                        r_size <= sclp_pkg::NC_W'(1);
                        r_amax <= '0;
                    end
                end
                sclp_pkg::S_R_STEP: begin
                    if (w_more)            r_pos <= r_pos + 1'b1;
                    else if (r_sp != '0)   r_sp  <= r_sp - 1'b1;
                end
                sclp_pkg::S_R_ADJ: ;
                sclp_pkg::S_R_CMP: begin
                    if (r_cp_q == '0) begin
                        r_size <= r_size + 1'b1;
                        r_sp   <= r_sp + 1'b1;
                        r_node <= r_ia_q;
                    end
                end
                sclp_pkg::S_R_BEST: if (r_bs_q > r_amax) r_amax <= r_bs_q;
                sclp_pkg::S_R_DONE: if (w_cand > r_best) r_best <= w_cand;
                sclp_pkg::S_FIN: begin
                    if (i_out_free) begin
                        r_tot <= '0;
                        r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/scc_condensed_longest_path_top.sv */
// ----------------------------------------------------------------------------
// scc_condensed_longest_path_top
// Loads directed edges, then on a run finds strongly connected components
// and reports the largest component-size total along any condensed path.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    opcode, source_node, target_node
//  o_rsp     out  valid/ready    best_path_nodes, edge_overflow
//  i_cfg     in   write enable   node_count (11 bits)
//
//  Edge loads: one transfer per cycle while idle.
//  A run is stepped by the sequencer through the single read port of each memory.
//  i_req.ready stays low during a run; edge loads continue while a result
//  waits in the output register, a new run finishes only once it drains.
//  Reset (synchronous, active low) empties the edge store, node_count = 1024.
//
module scc_condensed_longest_path_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sclp_pkg::FIELD_W-1:0] i_cfg_data,
    sclp_req_if.sink                     i_req,
    sclp_rsp_if.source                   o_rsp
);

    logic [sclp_pkg::FIELD_W-1:0] r_node_count;
    logic                         r_out_valid;
    logic [sclp_pkg::FIELD_W-1:0] r_out_best;
    logic                         r_out_ovf;
    logic                         w_out_free;
    sclp_pkg::t_core_cmd          w_cmd;
    sclp_pkg::t_core_sts          w_sts;

    // input side: accepted only while the sequencer is idle
    assign i_req.ready = w_sts.idle;

    always_comb begin
        w_cmd.load       = i_req.valid && w_sts.idle && (i_req.opcode == sclp_pkg::OP_ADD);
        w_cmd.run        = i_req.valid && w_sts.idle && (i_req.opcode == sclp_pkg::OP_RUN);
        w_cmd.src        = i_req.source_node;
        w_cmd.dst        = i_req.target_node;
        w_cmd.node_count = r_node_count;
    end

    // result slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_rsp.ready;

    sclp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_out_free (w_out_free),
        .o_sts      (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= sclp_pkg::FIELD_W'(sclp_pkg::MAX_NODES);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            r_out_best <= sclp_pkg::FIELD_W'(w_sts.best);
            r_out_ovf  <= w_sts.ovf;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.best_path_nodes = r_out_best;
    assign o_rsp.edge_overflow   = r_out_ovf;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for scc_condensed_longest_path_top. Edge loads and runs
// go in through the request channel with random gaps. A directed table comes
// first, then random graphs at several vertex counts. Table runs are checked
// against row answers, others against an in-bench component/longest-path model.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT   = 3_000_000;
    localparam int  DRAIN_CYCLES  = 50;    // settle time after the last answer
    localparam int  HOLD_CYCLES   = 3000;  // one long back-pressure stretch
    localparam int  HOLD_AT       = 7;     // answer index that takes the hold
    localparam int  RANDOM_ITEMS  = 420;

    typedef enum logic [1:0] { ROW_ADD, ROW_RUN, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        logic [sclp_pkg::FIELD_W-1:0] a;        // source, or node count for ROW_CFG
        logic [sclp_pkg::FIELD_W-1:0] b;        // target
        bit                           typed;    // answer given in the row
        logic [sclp_pkg::FIELD_W-1:0] best;
        logic                         ovf;
    } t_row;

    typedef struct {
        logic [sclp_pkg::FIELD_W-1:0] best;
        logic                         ovf;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sclp_pkg::FIELD_W-1:0] i_cfg_data = '0;

    sclp_req_if req_if ();
    sclp_rsp_if rsp_if ();

    scc_condensed_longest_path_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: edge store, overflow flag, vertex count.
    // ------------------------------------------------------------------------
    logic [sclp_pkg::FIELD_W-1:0] vertex_cnt = sclp_pkg::FIELD_W'(sclp_pkg::MAX_NODES);
    int unsigned        edge_src_q[$];
    int unsigned        edge_dst_q[$];
    bit                 dropped_edge;

    // working stores, rebuilt per run
    int unsigned succ_q [sclp_pkg::MAX_NODES][$];
    int unsigned pred_q [sclp_pkg::MAX_NODES][$];
    int unsigned member_q [sclp_pkg::MAX_NODES][$];
    bit          seen [sclp_pkg::MAX_NODES];
    int unsigned comp_id [sclp_pkg::MAX_NODES];     // 0 = unlabeled, else 1..
    int unsigned comp_sz [sclp_pkg::MAX_NODES];
    int unsigned comp_in [sclp_pkg::MAX_NODES];
    int unsigned comp_best [sclp_pkg::MAX_NODES];

    t_answer     answer_q[$];
    int          fail_cnt;
    int          answers_seen;
    int unsigned cycle_cnt;
    int unsigned items_sent;

    // Edge load: out-of-range endpoints vanish silently, a full store flags.
    function automatic void store_edge(logic [sclp_pkg::FIELD_W-1:0] src,
                                       logic [sclp_pkg::FIELD_W-1:0] dst);
        if (src == 0 || dst == 0 || src > sclp_pkg::MAX_NODES || dst > sclp_pkg::MAX_NODES)
            return;
        if (edge_src_q.size() >= sclp_pkg::MAX_EDGES) begin
            dropped_edge = 1'b1;
            return;
        end
        edge_src_q = {edge_src_q, 32'(src) - 32'd1};
        edge_dst_q = {edge_dst_q, 32'(dst) - 32'd1};
    endfunction

    // Kosaraju labeling, then Kahn order over the condensation keeping the
    // heaviest path (sum of component sizes) ending at each component.
    function automatic t_answer condensed_longest_path();
        int unsigned n, ncomp, s, u, w, p, top, d, cand, cur, best;
        int unsigned order_q[$], stk_v[$], stk_p[$], ready_q[$];
        t_answer     ans;
        n = (32'(vertex_cnt) > sclp_pkg::MAX_NODES) ? sclp_pkg::MAX_NODES : 32'(vertex_cnt);
        for (int v = 0; v < n; v++) begin
            succ_q[v].delete();
            pred_q[v].delete();
            member_q[v].delete();
            seen[v] = 1'b0;
            comp_id[v] = 0;
            comp_sz[v] = 0;
            comp_in[v] = 0;
            comp_best[v] = 0;
        end
        foreach (edge_src_q[e])
            if (edge_src_q[e] < n && edge_dst_q[e] < n) begin
                succ_q[edge_src_q[e]] = {succ_q[edge_src_q[e]], edge_dst_q[e]};
                pred_q[edge_dst_q[e]] = {pred_q[edge_dst_q[e]], edge_src_q[e]};
            end

        // forward walk, finishing order
        for (s = 0; s < n; s++) begin
            if (seen[s]) continue;
            seen[s] = 1'b1;
            stk_v = '{s};
            stk_p = '{0};
            while (stk_v.size() > 0) begin
                top = stk_v.size() - 1;
                u = stk_v[top];
                p = stk_p[top];
                if (p < succ_q[u].size()) begin
                    stk_p[top] = p + 1;
                    w = succ_q[u][p];
                    if (!seen[w]) begin
                        seen[w] = 1'b1;
                        stk_v = {stk_v, w};
                        stk_p = {stk_p, 32'd0};
                    end
                end else begin
                    void'(stk_v.pop_back());
                    void'(stk_p.pop_back());
                    order_q = {order_q, u};
                end
            end
        end

        // reverse walk, latest finisher first
        ncomp = 0;
        for (int i = order_q.size(); i > 0; i--) begin
            s = order_q[i-1];
            if (comp_id[s] != 0) continue;
            ncomp++;
            comp_id[s] = ncomp;
            comp_sz[ncomp-1]++;
            stk_v = '{s};
            stk_p = '{0};
            while (stk_v.size() > 0) begin
                top = stk_v.size() - 1;
                u = stk_v[top];
                p = stk_p[top];
                if (p < pred_q[u].size()) begin
                    stk_p[top] = p + 1;
                    w = pred_q[u][p];
                    if (comp_id[w] == 0) begin
                        comp_id[w] = ncomp;
                        comp_sz[ncomp-1]++;
                        stk_v = {stk_v, w};
                        stk_p = {stk_p, 32'd0};
                    end
                end else begin
                    void'(stk_v.pop_back());
                    void'(stk_p.pop_back());
                end
            end
        end

        for (int v = 0; v < n; v++) begin
            member_q[comp_id[v]-1] = {member_q[comp_id[v]-1], 32'(v)};
            foreach (succ_q[v][k])
                if (comp_id[succ_q[v][k]] != comp_id[v])
                    comp_in[comp_id[succ_q[v][k]]-1]++;
        end

        for (int c = 0; c < ncomp; c++)
            if (comp_in[c] == 0) begin
                comp_best[c] = comp_sz[c];
                ready_q = {ready_q, 32'(c)};
            end
        while (ready_q.size() > 0) begin
            cur = ready_q.pop_front();
            foreach (member_q[cur][m]) begin
                u = member_q[cur][m];
                foreach (succ_q[u][k]) begin
                    d = comp_id[succ_q[u][k]] - 1;
                    if (d == cur) continue;
                    cand = comp_best[cur] + comp_sz[d];
                    if (cand > comp_best[d]) comp_best[d] = cand;
                    if (comp_in[d] > 0) begin
                        comp_in[d]--;
                        if (comp_in[d] == 0) ready_q = {ready_q, d};
                    end
                end
            end
        end

        best = 0;
        for (int c = 0; c < ncomp; c++)
            if (comp_best[c] > best) best = comp_best[c];
        ans.best = sclp_pkg::FIELD_W'(best);
        ans.ovf = dropped_edge;
        edge_src_q.delete();
        edge_dst_q.delete();
        dropped_edge = 1'b0;
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid/payload change at the falling edge; the transfer is
    // seen at the rising edge, where the predictor is updated.
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic [sclp_pkg::FIELD_W-1:0] src,
                             logic [sclp_pkg::FIELD_W-1:0] dst,
                             bit typed = 1'b0, t_answer given = '{default: '0});
        t_answer ans;
        repeat ($urandom_range(0, 8)) @(negedge i_clk) req_if.valid <= 1'b0;
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.source_node <= src;
        req_if.target_node <= dst;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
        end
        items_sent++;
        if (op == sclp_pkg::OP_ADD) begin
            store_edge(src, dst);
        end else begin
            ans = condensed_longest_path();
            // a typed row answer stands in for the predicted one
            answer_q = {answer_q, (typed ? given : ans)};
        end
    endtask

    // Register write only with the block quiet: request withdrawn, all
    // answers in, plus margin for any edge load still being absorbed.
    task automatic write_vertex_cnt(logic [sclp_pkg::FIELD_W-1:0] value);
        @(negedge i_clk) req_if.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_data   <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vertex_cnt = value;
    endtask

    // Mostly edges inside 1..n, some with endpoints above n, a few raw.
    task automatic send_random_edge(int unsigned n);
        int unsigned r, hi;
        logic [sclp_pkg::FIELD_W-1:0] a, b;
        r  = $urandom_range(0, 19);
        hi = (n == 0 || n > sclp_pkg::MAX_NODES) ? sclp_pkg::MAX_NODES : n;
        if (r < 15) begin
            a = sclp_pkg::FIELD_W'($urandom_range(1, hi));
            b = sclp_pkg::FIELD_W'($urandom_range(1, hi));
        end else if (r < 17) begin
            a = sclp_pkg::FIELD_W'($urandom_range(1, sclp_pkg::MAX_NODES));
            b = sclp_pkg::FIELD_W'($urandom_range(1, sclp_pkg::MAX_NODES));
        end else begin
            a = sclp_pkg::FIELD_W'($urandom_range(0, 2047));
            b = sclp_pkg::FIELD_W'($urandom_range(0, 2047));
        end
        send_item(sclp_pkg::OP_ADD, a, b);
    endtask

    // Directed table: reset state, endpoint extremes, ignored endpoints,
    // vertex count zero, edges above the vertex count, oversized count,
    // self loop and a chain through a two-vertex cycle.
    t_row dir_rows[] = '{
        '{ROW_RUN, 11'd0,    11'd0,    1'b1, 11'd1, 1'b0},
        '{ROW_ADD, 11'd1,    11'd1024, 1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd1024, 11'd1,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd0,    11'd5,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd2047, 11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd7,    11'd1025, 1'b0, 11'd0, 1'b0},
        '{ROW_RUN, 11'd2047, 11'd2047, 1'b1, 11'd2, 1'b0},
        '{ROW_CFG, 11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd1,    11'd1,    1'b0, 11'd0, 1'b0},
        '{ROW_RUN, 11'd0,    11'd0,    1'b1, 11'd0, 1'b0},
        '{ROW_CFG, 11'd1,    11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd1,    11'd1,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd1,    11'd2,    1'b0, 11'd0, 1'b0},
        '{ROW_RUN, 11'd0,    11'd0,    1'b1, 11'd1, 1'b0},
        '{ROW_CFG, 11'd2047, 11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd3,    11'd4,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd4,    11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd4,    11'd5,    1'b0, 11'd0, 1'b0},
        '{ROW_RUN, 11'd0,    11'd0,    1'b1, 11'd3, 1'b0},
        '{ROW_CFG, 11'd5,    11'd0,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd1,    11'd2,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd2,    11'd3,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd3,    11'd2,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd3,    11'd4,    1'b0, 11'd0, 1'b0},
        '{ROW_ADD, 11'd4,    11'd5,    1'b0, 11'd0, 1'b0},
        '{ROW_RUN, 11'd0,    11'd0,    1'b1, 11'd5, 1'b0}
    };

    initial begin
        int unsigned phase, n_edges;
        t_answer     given;
        req_if.valid       = 1'b0;
        req_if.opcode      = sclp_pkg::OP_ADD;
        req_if.source_node = '0;
        req_if.target_node = '0;
        rsp_if.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            given = '{best: dir_rows[i].best, ovf: dir_rows[i].ovf};
            case (dir_rows[i].kind)
                ROW_ADD: begin
                    send_item(sclp_pkg::OP_ADD, dir_rows[i].a, dir_rows[i].b);
                end
                ROW_RUN: begin
                    send_item(sclp_pkg::OP_RUN, dir_rows[i].a, dir_rows[i].b,
                              dir_rows[i].typed, given);
                end
                default: begin
                    write_vertex_cnt(dir_rows[i].a);
                end
            endcase
        end

        // Random graphs. The first phases keep the same vertex count so the
        // sender keeps pushing through the receiver's long hold.
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase >= 8 && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_vertex_cnt(11'd1024);
                    1:       write_vertex_cnt(11'd2047);
                    2:       write_vertex_cnt(11'd1);
                    3:       write_vertex_cnt(11'd0);
                    4:       write_vertex_cnt(sclp_pkg::FIELD_W'($urandom_range(17, 64)));
                    default: write_vertex_cnt(sclp_pkg::FIELD_W'($urandom_range(2, 16)));
                endcase
            end
            n_edges = $urandom_range(0, 24);
            repeat (n_edges) send_random_edge(32'(vertex_cnt));
            send_item(sclp_pkg::OP_RUN, sclp_pkg::FIELD_W'($urandom_range(0, 2047)),
                      sclp_pkg::FIELD_W'($urandom_range(0, 2047)));
            phase++;
        end
        @(negedge i_clk) req_if.valid <= 1'b0;

        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls before each transfer, one long hold.
    // ------------------------------------------------------------------------
    initial begin
        t_answer want;
        @(posedge i_rst_n);
        forever begin
            if (answers_seen == HOLD_AT) begin
                // long hold: the output register fills and requests back up
                @(negedge i_clk) rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            repeat ($urandom_range(0, 8)) @(negedge i_clk) rsp_if.ready <= 1'b0;
            @(negedge i_clk) rsp_if.ready <= 1'b1;
            forever begin
                @(posedge i_clk);
                if (rsp_if.valid) break;
            end
            answers_seen++;
            if (answer_q.size() == 0) begin
                $error("answer transfer with none expected: best_path_nodes %0d",
                       rsp_if.best_path_nodes);
                fail_cnt++;
            end else begin
                want = answer_q.pop_front();
                if (rsp_if.best_path_nodes !== want.best) begin
                    $error("best_path_nodes: expected %0d, actual %0d",
                           want.best, rsp_if.best_path_nodes);
                    fail_cnt++;
                end
                if (rsp_if.edge_overflow !== want.ovf) begin
                    $error("edge_overflow: expected %0b, actual %0b",
                           want.ovf, rsp_if.edge_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
